@@ rtl/reload_down_counter_timer_defines.svh @@
// ----------------------------------------------------------------------------
// Reload down-counter timer: assertion macros
// Shared concurrent-assertion shorthands, clocked on clk with async reset.
// ----------------------------------------------------------------------------
`ifndef RELOAD_DOWN_COUNTER_TIMER_DEFINES_SVH
`define RELOAD_DOWN_COUNTER_TIMER_DEFINES_SVH

// Same-cycle implication
`define RDCT_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("timer assertion failed");

// Next-cycle implication
`define RDCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("timer assertion failed");

`endif

@@ rtl/rdct_pkg.sv @@
// ----------------------------------------------------------------------------
// rdct_pkg
// Types and constants shared by the timer controller, datapath and top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rdct_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned OFF_W    = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned MAXT_W   = 16;

    // Transaction kinds
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // Register map
    localparam logic [OFF_W-1:0] OFF_RELOAD_LO = 3'd0;
    localparam logic [OFF_W-1:0] OFF_RELOAD_HI = 3'd1;
    localparam logic [OFF_W-1:0] OFF_COUNT_LO  = 3'd2;
    localparam logic [OFF_W-1:0] OFF_COUNT_HI  = 3'd3;
    localparam logic [OFF_W-1:0] OFF_CONTROL   = 3'd4;
    localparam logic [OFF_W-1:0] OFF_STATUS    = 3'd5;
    localparam logic [OFF_W-1:0] OFF_ACK       = 3'd6;

    // Control byte bits
    localparam int unsigned CTL_ENABLE = 0;
    localparam int unsigned CTL_AUTO   = 1;
    localparam int unsigned CTL_IRQEN  = 2;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture incoming transaction
        logic step;    // advance one tick
        logic finish;  // apply access, register result
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;    // nothing left to do for the current transaction
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/rdct_in_if.sv @@
// ----------------------------------------------------------------------------
// rdct_in_if
// Request channel: valid/ready plus one timer transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rdct_in_if;
    logic                            valid;
    logic                            ready;
    logic [rdct_pkg::MODE_W-1:0]     mode;
    logic [rdct_pkg::TICK_W-1:0]     tick_count;
    logic [rdct_pkg::OFF_W-1:0]      reg_offset;
    logic [rdct_pkg::BYTE_W-1:0]     write_data;

    modport source (output valid, output mode, output tick_count, output reg_offset,
                    output write_data, input ready);
    modport sink   (input valid, input mode, input tick_count, input reg_offset,
                    input write_data, output ready);
endinterface

`default_nettype wire

@@ rtl/rdct_out_if.sv @@
// ----------------------------------------------------------------------------
// rdct_out_if
// Response channel: valid/ready plus read data and interrupt level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rdct_out_if;
    logic                            valid;
    logic                            ready;
    logic [rdct_pkg::BYTE_W-1:0]     read_data;
    logic                            irq_pending;

    modport source (output valid, output read_data, output irq_pending, input ready);
    modport sink   (input valid, input read_data, input irq_pending, output ready);
endinterface

`default_nettype wire

@@ rtl/rdct_datapath.sv @@
// ----------------------------------------------------------------------------
// rdct_datapath
// Timer state, captured transaction, tick counter and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rdct_datapath #(
    parameter int unsigned MAX_TICKS = 255
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rdct_pkg::dp_cmd_t             cmd,
    output rdct_pkg::dp_status_t               status,
    input  wire logic [rdct_pkg::MODE_W-1:0]   mode,
    input  wire logic [rdct_pkg::TICK_W-1:0]   tick_count,
    input  wire logic [rdct_pkg::OFF_W-1:0]    reg_offset,
    input  wire logic [rdct_pkg::BYTE_W-1:0]   write_data,
    output logic      [rdct_pkg::BYTE_W-1:0]   read_data,
    output logic                               irq_pending
);

    // burst length never exceeds the smaller of the tick field and MAX_TICKS
    localparam int unsigned TICK_MAX = (1 << rdct_pkg::TICK_W) - 1;
    localparam int unsigned REM_MAX  = (MAX_TICKS < TICK_MAX) ? MAX_TICKS : TICK_MAX;
    localparam int unsigned REM_W    = $clog2(REM_MAX + 1);

    logic [rdct_pkg::CNT_W-1:0]  reload_reg, reload_next;
    logic [rdct_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [rdct_pkg::BYTE_W-1:0] ctl_reg, ctl_next;
    logic                        ovf_reg, ovf_next;
    logic [rdct_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [rdct_pkg::OFF_W-1:0]  off_reg, off_next;
    logic [rdct_pkg::BYTE_W-1:0] wdata_reg, wdata_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [rdct_pkg::BYTE_W-1:0] rd_reg, rd_next;
    logic                        irq_reg, irq_next;
    logic [rdct_pkg::BYTE_W-1:0] rd_mux;
    logic                        sat;

    // saturate the requested burst length
    assign sat = ({{(rdct_pkg::MAXT_W - rdct_pkg::TICK_W){1'b0}}, tick_count}
                  > rdct_pkg::MAXT_W'(MAX_TICKS));

    // register read mux
    always_comb
    begin
        case (off_reg)
            rdct_pkg::OFF_RELOAD_LO: rd_mux = reload_reg[7:0];
            rdct_pkg::OFF_RELOAD_HI: rd_mux = reload_reg[15:8];
            rdct_pkg::OFF_COUNT_LO:  rd_mux = count_reg[7:0];
            rdct_pkg::OFF_COUNT_HI:  rd_mux = count_reg[15:8];
            rdct_pkg::OFF_CONTROL:   rd_mux = ctl_reg;
            rdct_pkg::OFF_STATUS:    rd_mux = {{(rdct_pkg::BYTE_W-1){1'b0}}, ovf_reg};
            default:                 rd_mux = '0;
        endcase
    end

    // next-state logic
    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        ctl_next    = ctl_reg;
        ovf_next    = ovf_reg;
        mode_next   = mode_reg;
        off_next    = off_reg;
        wdata_next  = wdata_reg;
        rem_next    = rem_reg;
        rd_next     = rd_reg;
        irq_next    = irq_reg;

        if (cmd.load)
        begin
            mode_next  = mode;
            off_next   = reg_offset;
            wdata_next = write_data;
            rem_next   = sat ? REM_W'(MAX_TICKS) : REM_W'(tick_count);
        end

        // one tick per cycle
        if (cmd.step)
        begin
            rem_next = rem_reg - REM_W'(1);
            if (count_reg == '0)
            begin
                ovf_next = 1'b1;
                if (ctl_reg[rdct_pkg::CTL_AUTO])
                    count_next = reload_reg;
                else
                    ctl_next[rdct_pkg::CTL_ENABLE] = 1'b0;
            end
            else
            begin
                count_next = count_reg - rdct_pkg::CNT_W'(1);
            end
        end

        // register write and response capture
        if (cmd.finish)
        begin
            if (mode_reg == rdct_pkg::MODE_WRITE)
            begin
                case (off_reg)
                    rdct_pkg::OFF_RELOAD_LO: reload_next[7:0]  = wdata_reg;
                    rdct_pkg::OFF_RELOAD_HI: reload_next[15:8] = wdata_reg;
                    rdct_pkg::OFF_CONTROL:
                    begin
                        ctl_next = wdata_reg;
                        if (wdata_reg[rdct_pkg::CTL_ENABLE])
                            count_next = reload_reg;
                    end
                    rdct_pkg::OFF_ACK:       ovf_next = 1'b0;
                    default:                 ;
                endcase
            end
            rd_next  = (mode_reg == rdct_pkg::MODE_READ) ? rd_mux : '0;
            irq_next = ovf_next & ctl_next[rdct_pkg::CTL_IRQEN];
        end
    end

    // timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            count_reg  <= '0;
            ctl_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            ctl_reg    <= ctl_next;
            ovf_reg    <= ovf_next;
        end
    end

    // transaction and response payload
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        off_reg   <= off_next;
        wdata_reg <= wdata_next;
        rem_reg   <= rem_next;
        rd_reg    <= rd_next;
        irq_reg   <= irq_next;
    end

    assign status.done = (mode_reg != rdct_pkg::MODE_TICK) || (rem_reg == '0)
                         || !ctl_reg[rdct_pkg::CTL_ENABLE];
    assign read_data   = rd_reg;
    assign irq_pending = irq_reg;

endmodule

`default_nettype wire

@@ rtl/rdct_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdct_ctrl
// Sequencer: accepts a transaction, runs it, owns the response valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "reload_down_counter_timer_defines.svh"

module rdct_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rdct_pkg::dp_cmd_t          cmd,
    input  wire rdct_pkg::dp_status_t  status
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t st_reg, st_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;

    // accept only when the response slot is free by the next edge
    assign in_ready = (st_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // commands
    always_comb
    begin
        cmd.load   = in_fire;
        cmd.step   = (st_reg == ST_EXEC) && !status.done;
        cmd.finish = (st_reg == ST_EXEC) && status.done;
    end

    // next state
    always_comb
    begin
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    st_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.done)
                begin
                    st_next        = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `RDCT_ASSERT_NEXT(a_fire_to_exec, clk, rst_n, in_fire, st_reg == ST_EXEC)
    `RDCT_ASSERT_SAME(a_busy_blocks, clk, rst_n, st_reg == ST_EXEC, !in_ready)
    `RDCT_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_reg)
    `RDCT_ASSERT_SAME(a_finish_free, clk, rst_n, cmd.finish, !out_valid_reg)

endmodule

`default_nettype wire

@@ rtl/reload_down_counter_timer.sv @@
// ----------------------------------------------------------------------------
// reload_down_counter_timer
// 16-bit reload down-counter timer behind a byte register map.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per valid/ready handshake: a tick burst
//   (mode 0), a register read (mode 1) or a register write (mode 2).
//   rsp returns exactly one transaction per request with read_data (zero
//   unless a read) and irq_pending after the request took effect.
//   A read or write is applied and its response registered once the
//   request is captured; a tick burst first runs N = min(tick_count,
//   MAX_TICKS) ticks, fewer if a one-shot overflow stops it or the timer
//   is disabled. The tick loop in the datapath advances the counter one
//   tick per cycle. One request is in flight at a time; the next is
//   accepted no earlier than the cycle its predecessor's response is
//   taken.
//   If the receiver stalls, the response holds in its output register and
//   cmd.ready stays low until the slot frees up.
//   Reset clears reload, counter, control and overflow and leaves both
//   channels idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module reload_down_counter_timer #(
    parameter int unsigned MAX_TICKS = 255
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rdct_in_if.sink     cmd,
    rdct_out_if.source  rsp
);

    rdct_pkg::dp_cmd_t    dp_cmd;
    rdct_pkg::dp_status_t dp_status;
    logic                 in_ready;
    logic                 out_valid;

    rdct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    rdct_datapath #(
        .MAX_TICKS (MAX_TICKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .mode        (cmd.mode),
        .tick_count  (cmd.tick_count),
        .reg_offset  (cmd.reg_offset),
        .write_data  (cmd.write_data),
        .read_data   (rsp.read_data),
        .irq_pending (rsp.irq_pending)
    );

    assign cmd.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

`default_nettype wire
